// ===== rtl/affine_transform_accumulator_3d_unit_macros.svh =====
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_3D_UNIT_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_3D_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ATAC_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ATAC_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/atac_pkg.sv =====
package atac_pkg;

	localparam int DATA_W    = 32;
	localparam int OPND_W    = 33;
	localparam int TRIG_W    = 18;
	localparam int CMD_W     = 3;
	localparam int PLANE_W   = 2;
	localparam int REG_IDX_W = 2;
	localparam int ENT_W     = 4;
	localparam int NUM_ENT   = 12;
	localparam int ADDR_W    = ENT_W + 1;
	localparam int S_TDATA_W = 136;
	localparam int M_TDATA_W = 96;

	typedef enum logic [CMD_W-1:0] {
		CMD_IDENT  = 3'd0,
		CMD_TRANS  = 3'd1,
		CMD_SCALE  = 3'd2,
		CMD_ROTX   = 3'd3,
		CMD_ROTY   = 3'd4,
		CMD_ROTZ   = 3'd5,
		CMD_MIRROR = 3'd6,
		CMD_POINT  = 3'd7
	} cmd_t;

	typedef enum logic [PLANE_W-1:0] {
		PLANE_XY = 2'd0,
		PLANE_YZ = 2'd1,
		PLANE_XZ = 2'd2
	} plane_t;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_REF_X = 2'd0,
		REG_REF_Y = 2'd1,
		REG_REF_Z = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRO,
		ST_RUN,
		ST_DRAIN,
		ST_HOLD
	} state_t;

	typedef enum logic [1:0] {
		STEP_OFFSET,
		STEP_MATRIX,
		STEP_POINT
	} step_kind_t;

	typedef struct packed {
		step_kind_t        kind;
		logic              first;
		logic              last;
		logic [ENT_W-1:0]  dst;
	} mac_tag_t;

endpackage

// ===== rtl/atac_mac.sv =====
module atac_mac #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  atac_pkg::mac_tag_t                    in_tag,
	input  logic signed [atac_pkg::OPND_W-1:0]    coef,
	input  logic signed [atac_pkg::OPND_W-1:0]    data,
	output logic                                  out_valid,
	output atac_pkg::mac_tag_t                    out_tag,
	output logic signed [atac_pkg::DATA_W-1:0]    out_value,
	output logic                                  out_sat
);
	import atac_pkg::*;

	localparam int PROD_W = 2 * OPND_W;
	localparam int SH_W   = PROD_W - FRAC_BITS;
	localparam int ACC_W  = SH_W + 2;
	localparam int HI_W   = ACC_W - DATA_W + 1;

	logic                      valid_s2;
	mac_tag_t                  tag_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [ACC_W-1:0]   term;
	logic signed [ACC_W-1:0]   sum;
	logic [HI_W-1:0]           hi;
	logic                      pos_ovf;
	logic                      neg_ovf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			prod_s2 <= PROD_W'(coef) * PROD_W'(data);
			tag_s2  <= in_tag;
		end
		if (valid_s2) begin
			acc_q <= sum;
		end
	end

	// floor shift, then exact sum of truncated products
	assign term = ACC_W'(prod_s2 >>> FRAC_BITS);
	assign sum  = tag_s2.first ? term : acc_q + term;

	assign hi      = sum[ACC_W-1:DATA_W-1];
	assign pos_ovf = !sum[ACC_W-1] && (|hi);
	assign neg_ovf = sum[ACC_W-1] && !(&hi);

	always_comb begin
		if (pos_ovf) begin
			out_value = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (neg_ovf) begin
			out_value = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			out_value = sum[DATA_W-1:0];
		end
	end

	assign out_sat   = pos_ovf || neg_ovf;
	assign out_valid = valid_s2 && tag_s2.last;
	assign out_tag   = tag_s2;

endmodule

// ===== rtl/affine_transform_accumulator_3d_unit.sv =====
// channel | dir | tdata fields, lowest bit up                              | tuser
// s_*     | in  | operand_a, operand_b, operand_c, cos_value, sin_value,   | cmd
//         |     | mirror_plane, zero pad                                     |
// m_*     | out | out_x, out_y, out_z                                        | overflow
// cfg_*   | in  | cfg_index selects ref_x, ref_y, ref_z; cfg_data is value   | -
//
// identity takes effect on acceptance; translate, rotate and mirror run a matrix composition;
// scale first computes its offsets; point runs its steps and then loads the output register
// run time is set by one shared 33x33 multiply-accumulate unit that takes one product a cycle
// (four per matrix entry) from a matrix memory with one read and one write port and a registered read
// reset restores the identity matrix at once (bank valid flag), refs clear to zero
// a result waiting on m_tready holds the next point and the input behind it; compositions ahead of it keep running

`include "affine_transform_accumulator_3d_unit_macros.svh"

module affine_transform_accumulator_3d_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	// command transaction
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	// operand_a, operand_b, operand_c, cos_value, sin_value, mirror_plane
	input  logic [atac_pkg::S_TDATA_W-1:0]          s_tdata,
	// cmd
	input  logic [atac_pkg::CMD_W-1:0]              s_tuser,
	// result transaction
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	// out_x, out_y, out_z
	output logic [atac_pkg::M_TDATA_W-1:0]          m_tdata,
	// overflow
	output logic [0:0]                              m_tuser,
	// register writes
	input  logic                                    cfg_we,
	input  logic [atac_pkg::REG_IDX_W-1:0]          cfg_index,
	input  logic [atac_pkg::DATA_W-1:0]             cfg_data
);
	import atac_pkg::*;

	localparam logic signed [OPND_W-1:0] ONE_O    = OPND_W'(1) << FRAC_BITS;
	localparam logic signed [OPND_W-1:0] NEG_ONE  = -ONE_O;
	localparam logic [ENT_W-1:0]         LAST_PRO = ENT_W'(2);
	localparam logic [ENT_W-1:0]         LAST_PT  = ENT_W'(2);
	localparam logic [ENT_W-1:0]         LAST_MAT = ENT_W'(NUM_ENT - 1);
	localparam int                       MEM_DEPTH = 1 << ADDR_W;

	// fsm
	state_t state_q, state_nxt;
	logic [ENT_W-1:0] cnt_o_q;
	logic [1:0]       cnt_k_q;
	logic             accept;
	logic             issue;
	logic             issue_end;
	logic             out_load;
	cmd_t             cmd_in;

	// command registers
	cmd_t                       cmd_q;
	logic signed [DATA_W-1:0]   p_q [3];
	logic signed [TRIG_W-1:0]   cos_q;
	logic signed [TRIG_W-1:0]   sin_q;
	logic [PLANE_W-1:0]         plane_q;
	logic signed [DATA_W-1:0]   ref_q [3];
	logic signed [DATA_W-1:0]   off_q [3];
	logic                       is_point;

	// matrix memory: two banks, composition reads one and writes the other
	logic [DATA_W-1:0]          mat_mem [MEM_DEPTH];
	logic                       cur_q;
	logic                       mat_valid_q;
	logic signed [DATA_W-1:0]   rdata_q;
	logic [ENT_W-1:0]           rd_idx;
	logic                       rd_en;
	logic                       mem_we;

	// elementary transform, rows by columns
	logic signed [OPND_W-1:0]   e_m [3][4];

	// issue stage
	mac_tag_t                   tag_i;
	logic signed [OPND_W-1:0]   coef_i;
	logic signed [OPND_W-1:0]   alt_i;
	logic                       src_mem_i;
	logic [1:0]                 row_i;
	logic [1:0]                 col_i;

	// read stage
	logic                       v_s1;
	mac_tag_t                   tag_s1;
	logic signed [OPND_W-1:0]   coef_s1;
	logic signed [OPND_W-1:0]   alt_s1;
	logic                       src_mem_s1;
	logic [ENT_W-1:0]           rd_idx_s1;
	logic signed [OPND_W-1:0]   data_s1;
	logic signed [OPND_W-1:0]   ident_s1;

	// mac results
	logic                       mac_valid;
	mac_tag_t                   mac_tag;
	logic signed [DATA_W-1:0]   mac_value;
	logic                       mac_sat;

	// point results
	logic signed [DATA_W-1:0]   res_q [3];
	logic                       res_ovf_q;

	// output register
	logic                       m_tvalid_q;
	logic [M_TDATA_W-1:0]       m_tdata_q;
	logic                       m_tuser_q;

	assign cmd_in   = cmd_t'(s_tuser);
	assign is_point = (cmd_q == CMD_POINT);
	assign issue_end = (cnt_k_q == 2'd3) && (cnt_o_q == (is_point ? LAST_PT : LAST_MAT));

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid && (cmd_in != CMD_IDENT)) begin
					state_nxt = (cmd_in == CMD_SCALE) ? ST_PRO : ST_RUN;
				end
			end
			ST_PRO: begin
				if (cnt_o_q == LAST_PRO) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (issue_end) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last product leaves the mac when the drain count reaches one
				if (cnt_k_q == 2'd1) begin
					state_nxt = is_point ? ST_HOLD : ST_IDLE;
				end
			end
			ST_HOLD: begin
				if (!m_tvalid_q || m_tready) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		s_tready = 1'b0;
		issue    = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE:  s_tready = 1'b1;
			ST_PRO:   issue    = 1'b1;
			ST_RUN:   issue    = 1'b1;
			ST_DRAIN: ;
			ST_HOLD:  out_load = !m_tvalid_q || m_tready;
			default:  ;
		endcase
	end

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_o_q <= '0;
			cnt_k_q <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					cnt_o_q <= '0;
					cnt_k_q <= '0;
				end
				ST_PRO: begin
					cnt_o_q <= (cnt_o_q == LAST_PRO) ? '0 : cnt_o_q + 1'b1;
				end
				ST_RUN: begin
					cnt_k_q <= cnt_k_q + 1'b1;
					if (cnt_k_q == 2'd3) begin
						cnt_o_q <= cnt_o_q + 1'b1;
					end
				end
				ST_DRAIN: cnt_k_q <= cnt_k_q + 1'b1;
				ST_HOLD:  ;
				default:  ;
			endcase
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q[0] <= '0;
			ref_q[1] <= '0;
			ref_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REF_X: ref_q[0] <= cfg_data;
				REG_REF_Y: ref_q[1] <= cfg_data;
				REG_REF_Z: ref_q[2] <= cfg_data;
				default:   ;
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= cmd_in;
			p_q[0]  <= s_tdata[31:0];
			p_q[1]  <= s_tdata[63:32];
			p_q[2]  <= s_tdata[95:64];
			cos_q   <= s_tdata[113:96];
			sin_q   <= s_tdata[131:114];
			plane_q <= s_tdata[133:132];
		end
	end

	// bank select and identity flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= 1'b0;
			mat_valid_q <= 1'b0;
		end else if (accept && (cmd_in == CMD_IDENT)) begin
			mat_valid_q <= 1'b0;
		end else if ((state_q == ST_DRAIN) && (cnt_k_q == 2'd1) && !is_point) begin
			cur_q       <= ~cur_q;
			mat_valid_q <= 1'b1;
		end
	end

	// elementary transform from the captured command
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 4; j++) begin
				e_m[i][j] = (i == j) ? ONE_O : '0;
			end
		end
		case (cmd_q)
			CMD_TRANS: begin
				e_m[0][3] = OPND_W'(p_q[0]);
				e_m[1][3] = OPND_W'(p_q[1]);
				e_m[2][3] = OPND_W'(p_q[2]);
			end
			CMD_SCALE: begin
				e_m[0][0] = OPND_W'(p_q[0]);
				e_m[1][1] = OPND_W'(p_q[1]);
				e_m[2][2] = OPND_W'(p_q[2]);
				e_m[0][3] = OPND_W'(off_q[0]);
				e_m[1][3] = OPND_W'(off_q[1]);
				e_m[2][3] = OPND_W'(off_q[2]);
			end
			CMD_ROTX: begin
				e_m[1][1] = OPND_W'(cos_q);
				e_m[1][2] = -OPND_W'(sin_q);
				e_m[2][1] = OPND_W'(sin_q);
				e_m[2][2] = OPND_W'(cos_q);
			end
			CMD_ROTY: begin
				e_m[0][0] = OPND_W'(cos_q);
				e_m[0][2] = OPND_W'(sin_q);
				e_m[2][0] = -OPND_W'(sin_q);
				e_m[2][2] = OPND_W'(cos_q);
			end
			CMD_ROTZ: begin
				e_m[0][0] = OPND_W'(cos_q);
				e_m[0][1] = -OPND_W'(sin_q);
				e_m[1][0] = OPND_W'(sin_q);
				e_m[1][1] = OPND_W'(cos_q);
			end
			CMD_MIRROR: begin
				// unused plane code runs as identity, leaving the matrix as is
				case (plane_q)
					PLANE_XY: e_m[2][2] = NEG_ONE;
					PLANE_YZ: e_m[0][0] = NEG_ONE;
					PLANE_XZ: e_m[1][1] = NEG_ONE;
					default:  ;
				endcase
			end
			default: ;
		endcase
	end

	// issue: one mac step per cycle
	always_comb begin
		tag_i       = '0;
		tag_i.kind  = STEP_MATRIX;
		coef_i      = '0;
		alt_i       = ONE_O;
		src_mem_i   = 1'b0;
		rd_idx      = '0;
		row_i       = cnt_o_q[3:2];
		col_i       = cnt_o_q[1:0];
		if (state_q == ST_PRO) begin
			// scale offset (one - s) * ref per axis
			tag_i.kind  = STEP_OFFSET;
			tag_i.first = 1'b1;
			tag_i.last  = 1'b1;
			tag_i.dst   = cnt_o_q;
			coef_i      = ONE_O - OPND_W'(p_q[cnt_o_q[1:0]]);
			alt_i       = OPND_W'(ref_q[cnt_o_q[1:0]]);
		end else if (is_point) begin
			// out[i] = sum m[i][k] * p[k] + m[i][3] * one
			tag_i.kind  = STEP_POINT;
			tag_i.first = (cnt_k_q == 2'd0);
			tag_i.last  = (cnt_k_q == 2'd3);
			tag_i.dst   = {2'b00, cnt_o_q[1:0]};
			src_mem_i   = 1'b1;
			rd_idx      = {cnt_o_q[1:0], cnt_k_q};
			if (cnt_k_q != 2'd3) begin
				coef_i = OPND_W'(p_q[cnt_k_q]);
			end else begin
				coef_i = ONE_O;
			end
		end else begin
			// t[i][j] = sum e[i][k] * m[k][j], plus e[i][3] in the last column
			tag_i.first = (cnt_k_q == 2'd0);
			tag_i.last  = (cnt_k_q == 2'd3);
			tag_i.dst   = cnt_o_q;
			if (cnt_k_q != 2'd3) begin
				src_mem_i = 1'b1;
				rd_idx    = {cnt_k_q, col_i};
				coef_i    = e_m[row_i][cnt_k_q];
			end else if (col_i == 2'd3) begin
				coef_i = e_m[row_i][3];
			end
		end
	end

	assign rd_en = issue && src_mem_i;

	// matrix memory, registered read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mat_mem[{cur_q, rd_idx}];
		end
		if (mem_we) begin
			mat_mem[{~cur_q, mac_tag.dst}] <= mac_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			tag_s1     <= tag_i;
			coef_s1    <= coef_i;
			alt_s1     <= alt_i;
			src_mem_s1 <= src_mem_i;
			rd_idx_s1  <= rd_idx;
		end
	end

	// a bank not yet written reads as the identity
	assign ident_s1 = (rd_idx_s1[3:2] == rd_idx_s1[1:0]) ? ONE_O : '0;
	assign data_s1  = !src_mem_s1 ? alt_s1 :
	                  mat_valid_q ? OPND_W'(rdata_q) : ident_s1;

	atac_mac #(
		.FRAC_BITS (FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_tag    (tag_s1),
		.coef      (coef_s1),
		.data      (data_s1),
		.out_valid (mac_valid),
		.out_tag   (mac_tag),
		.out_value (mac_value),
		.out_sat   (mac_sat)
	);

	assign mem_we = mac_valid && (mac_tag.kind == STEP_MATRIX);

	// scale offsets and point coordinates
	always_ff @(posedge clk) begin
		if (mac_valid && (mac_tag.kind == STEP_OFFSET)) begin
			off_q[mac_tag.dst[1:0]] <= mac_value;
		end
		if (mac_valid && (mac_tag.kind == STEP_POINT)) begin
			res_q[mac_tag.dst[1:0]] <= mac_value;
		end
		if (accept) begin
			res_ovf_q <= 1'b0;
		end else if (mac_valid && (mac_tag.kind == STEP_POINT) && mac_sat) begin
			res_ovf_q <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {res_q[2], res_q[1], res_q[0]};
			m_tuser_q <= res_ovf_q;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

	// the last step of a command leaves the mac exactly at the end of the drain
	`ATAC_ASSERT_IMP(a_drain_aligned, (state_q == ST_DRAIN) && (cnt_k_q == 2'd1), mac_valid, "last mac step not at drain end")
	// mac results only while a command runs
	`ATAC_ASSERT_IMP(a_mac_busy, mac_valid, (state_q == ST_PRO) || (state_q == ST_RUN) || (state_q == ST_DRAIN), "mac result outside a command")
	// bank swap only after a finished composition
	`ATAC_ASSERT_NXT(a_swap_at_end, (state_q == ST_RUN) || (state_q == ST_PRO) || (state_q == ST_HOLD), $stable(cur_q), "bank swapped mid command")
	// only a point transaction waits for the output register
	`ATAC_ASSERT_IMP(a_hold_point, state_q == ST_HOLD, is_point, "hold state without a point")

endmodule

// ===== sim/affine_transform_accumulator_3d_unit_test.sv =====
module affine_transform_accumulator_3d_unit_test;

	timeunit 1ns;
	timeprecision 1ps;

	import atac_pkg::*;

	localparam int     FRAC_BITS    = 16;
	localparam longint Q_ONE        = 64'sd1 << FRAC_BITS;
	localparam longint S32_HI       = 64'sd2147483647;
	localparam longint S32_LO       = -64'sd2147483648;
	localparam int     SETTLE       = 80;    // covers the longest composition, a scale
	localparam int     QUIET_LIMIT  = 4000;  // cycles with no transaction before giving up
	localparam int     HOLD_CYCLES  = 500;   // long output hold-off for the backpressure test
	localparam int     MAX_REPORTS  = 10;

	typedef struct {
		cmd_t               cmd;
		logic signed [31:0] a;
		logic signed [31:0] b;
		logic signed [31:0] c;
		logic signed [17:0] cs;
		logic signed [17:0] sn;
		logic [1:0]         plane;  // plain bits: the unused code 3 is driven too
	} command_t;

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
		logic        ovf;
	} point_result_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic [CMD_W-1:0]       s_tuser   = CMD_IDENT;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [0:0]             m_tuser;
	logic                   cfg_we    = 1'b0;
	logic [REG_IDX_W-1:0]   cfg_index = REG_REF_X;
	logic [DATA_W-1:0]      cfg_data  = '0;

	// shadow of the block: matrix rows of four and the scaling reference point
	longint        xform [3][4];
	longint        ref_pt [3];
	point_result_t pending_points [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_pending  = 1'b0;
	int hold_count    = 0;
	int mismatches    = 0;
	int quiet_cycles  = 0;

	affine_transform_accumulator_3d_unit #(
		.FRAC_BITS(FRAC_BITS)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	// product of two fixed-point values, truncated toward minus infinity
	function automatic longint floor_q(input longint v);
		return v >>> FRAC_BITS;
	endfunction

	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > S32_HI) begin
			ovf = 1'b1;
			return S32_HI;
		end
		if (v < S32_LO) begin
			ovf = 1'b1;
			return S32_LO;
		end
		return v;
	endfunction

	function automatic void unit_matrix(output longint m [3][4]);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 4; j++)
				m[i][j] = (i == j) ? Q_ONE : 64'sd0;
	endfunction

	// new matrix = elementary * old, every entry saturated on its own
	function automatic void premultiply(input longint e [3][4]);
		longint t [3][4];
		longint acc;
		bit     unused_ovf;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 4; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++)
					acc += floor_q(e[i][k] * xform[k][j]);
				if (j == 3)
					acc += e[i][3];
				t[i][j] = clamp32(acc, unused_ovf);
			end
		end
		xform = t;
	endfunction

	// applies one accepted command; returns 1 with the point when one comes out
	function automatic bit predict_command(input command_t it, output point_result_t r);
		longint e [3][4];
		longint p [3];
		longint s [3];
		longint cs;
		longint sn;
		longint acc;
		longint coord [3];
		bit     ovf;
		cs  = longint'(it.cs);
		sn  = longint'(it.sn);
		ovf = 1'b0;
		r   = '{default: '0};
		unit_matrix(e);
		case (it.cmd)
			CMD_IDENT: begin
				unit_matrix(xform);
				return 1'b0;
			end
			CMD_TRANS: begin
				e[0][3] = longint'(it.a);
				e[1][3] = longint'(it.b);
				e[2][3] = longint'(it.c);
			end
			CMD_SCALE: begin
				s[0] = longint'(it.a);
				s[1] = longint'(it.b);
				s[2] = longint'(it.c);
				// offset (1 - s) * ref keeps the reference point fixed
				for (int i = 0; i < 3; i++) begin
					e[i][i] = s[i];
					e[i][3] = clamp32(floor_q((Q_ONE - s[i]) * ref_pt[i]), ovf);
				end
			end
			CMD_ROTX: begin
				e[1][1] = cs;
				e[1][2] = -sn;
				e[2][1] = sn;
				e[2][2] = cs;
			end
			CMD_ROTY: begin
				e[0][0] = cs;
				e[0][2] = sn;
				e[2][0] = -sn;
				e[2][2] = cs;
			end
			CMD_ROTZ: begin
				e[0][0] = cs;
				e[0][1] = -sn;
				e[1][0] = sn;
				e[1][1] = cs;
			end
			CMD_MIRROR: begin
				if (it.plane == PLANE_XY)
					e[2][2] = -Q_ONE;
				else if (it.plane == PLANE_YZ)
					e[0][0] = -Q_ONE;
				else if (it.plane == PLANE_XZ)
					e[1][1] = -Q_ONE;
				else
					return 1'b0;  // spare plane code leaves the matrix alone
			end
			default: begin
				p[0] = longint'(it.a);
				p[1] = longint'(it.b);
				p[2] = longint'(it.c);
				for (int i = 0; i < 3; i++) begin
					acc = xform[i][3];
					for (int k = 0; k < 3; k++)
						acc += floor_q(xform[i][k] * p[k]);
					coord[i] = clamp32(acc, ovf);
				end
				r.x   = coord[0][31:0];
				r.y   = coord[1][31:0];
				r.z   = coord[2][31:0];
				r.ovf = ovf;
				return 1'b1;
			end
		endcase
		premultiply(e);
		return 1'b0;
	endfunction

	// ---------------------------------------------------------------- drivers

	function automatic command_t make_cmd(input cmd_t cmd, input logic signed [31:0] a,
			input logic signed [31:0] b, input logic signed [31:0] c,
			input logic signed [17:0] cs, input logic signed [17:0] sn, input logic [1:0] plane);
		command_t it;
		it.cmd   = cmd;
		it.a     = a;
		it.b     = b;
		it.c     = c;
		it.cs    = cs;
		it.sn    = sn;
		it.plane = plane;
		return it;
	endfunction

	// uniform value in [-span, span]
	function automatic logic signed [31:0] spread(input int unsigned span);
		return int'($urandom_range(0, 2 * span)) - int'(span);
	endfunction

	// every field drawn over its whole width, any command
	function automatic command_t noise_cmd();
		return make_cmd(cmd_t'($urandom_range(0, 7)), $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom_range(0, 3));
	endfunction

	// one command transaction; entered and left just after a rising edge
	task automatic send_command(input command_t it);
		int            gap;
		point_result_t r;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < send_idle_pct)
			gap++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W - 134){1'b0}}, it.plane, it.sn, it.cs, it.c, it.b, it.a};
		s_tuser  <= it.cmd;
		do
			@(posedge clk);
		while (!s_tready);
		if (predict_command(it, r))
			pending_points.push_back(r);
	endtask

	// stop offering, wait for every point, then let a composition finish
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_points.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// writes all three reference registers back to back; block must be idle
	task automatic write_refs(input logic signed [31:0] rx, input logic signed [31:0] ry,
			input logic signed [31:0] rz);
		logic signed [31:0] vals [3];
		reg_idx_t           idx [3];
		vals = '{rx, ry, rz};
		idx  = '{REG_REF_X, REG_REF_Y, REG_REF_Z};
		for (int i = 0; i < 3; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= vals[i];
			@(posedge clk);
			ref_pt[i] = longint'(vals[i]);
		end
		cfg_we <= 1'b0;
	endtask

	// ---------------------------------------------------------------- receiver and checker

	// random stalls, or a long hold-off counted here when one is requested
	always @(posedge clk) begin
		if (hold_pending) begin
			m_tready <= 1'b0;
			hold_count++;
			if (hold_count >= HOLD_CYCLES) begin
				hold_pending = 1'b0;
				hold_count   = 0;
			end
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic note_mismatch(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, exp_v, act_v);
	endtask

	// each result transaction against the oldest predicted point
	always @(posedge clk) begin
		point_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t unexpected result transaction %h", $realtime, m_tdata);
			end else begin
				want = pending_points.pop_front();
				if (m_tdata[31:0] !== want.x)
					note_mismatch("out_x", want.x, m_tdata[31:0]);
				if (m_tdata[63:32] !== want.y)
					note_mismatch("out_y", want.y, m_tdata[63:32]);
				if (m_tdata[95:64] !== want.z)
					note_mismatch("out_z", want.z, m_tdata[95:64]);
				if (m_tuser[0] !== want.ovf)
					note_mismatch("overflow", {31'b0, want.ovf}, {31'b0, m_tuser[0]});
			end
		end
	end

	// watchdog: a run of cycles with no transaction on either side ends the run
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t no transaction for %0d cycles", $realtime, QUIET_LIMIT);
			$display("FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// field extremes, every command, the special cases by hand
	task automatic test_directed_commands();
		logic signed [31:0] hi;
		logic signed [31:0] lo;
		hi = 32'sh7FFF_FFFF;
		lo = 32'sh8000_0000;
		// identity passes points through, even the extremes
		send_command(make_cmd(CMD_POINT, 32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
			0, 0, 0));
		send_command(make_cmd(CMD_POINT, hi, lo, 0, 18'sh1FFFF, -18'sh20000, 3));
		// translate to the extremes, then a point that saturates every axis
		send_command(make_cmd(CMD_TRANS, hi, lo, hi, $urandom, $urandom, $urandom_range(0, 3)));
		send_command(make_cmd(CMD_POINT, hi, lo, 32'sh0000_0001, 0, 0, 0));
		// identity ignores whatever sits in the operands
		send_command(make_cmd(CMD_IDENT, $urandom, $urandom, $urandom, $urandom, $urandom, 3));
		send_command(make_cmd(CMD_SCALE, 32'sh0002_0000, -32'sh0000_8000, 32'sh0003_0000,
			0, 0, 0));
		send_command(make_cmd(CMD_POINT, 32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
			0, 0, 0));
		send_command(make_cmd(CMD_ROTX, $urandom, $urandom, $urandom, 0, 18'sh10000, 0));
		send_command(make_cmd(CMD_ROTY, 0, 0, 0, -18'sh10000, 0, 1));
		send_command(make_cmd(CMD_ROTZ, 0, 0, 0, 18'sd39322, -18'sd52429, 2));
		send_command(make_cmd(CMD_POINT, 32'sh0003_8000, -32'sh0002_4000, 32'sh0007_0000,
			0, 0, 0));
		send_command(make_cmd(CMD_MIRROR, $urandom, $urandom, $urandom, 0, 0, PLANE_XY));
		send_command(make_cmd(CMD_MIRROR, 0, 0, 0, $urandom, $urandom, PLANE_YZ));
		send_command(make_cmd(CMD_MIRROR, 0, 0, 0, 0, 0, PLANE_XZ));
		// spare plane code must not touch the matrix
		send_command(make_cmd(CMD_MIRROR, 0, 0, 0, 0, 0, 2'd3));
		send_command(make_cmd(CMD_POINT, -32'sh0001_2345, 32'sh0010_0000, 32'sh0000_0003,
			0, 0, 0));
		// cosine and sine beyond one are taken as they are
		send_command(make_cmd(CMD_ROTZ, 0, 0, 0, 18'sh1FFFF, -18'sh20000, 0));
		send_command(make_cmd(CMD_POINT, 32'sh0000_8000, -32'sh0000_4000, 32'sh0001_0000,
			0, 0, 0));
		send_command(make_cmd(CMD_SCALE, lo, hi, 0, 0, 0, 0));
		send_command(make_cmd(CMD_POINT, 32'sh0000_0001, -32'sh0000_0001, hi, 0, 0, 0));
		send_command(make_cmd(CMD_IDENT, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(CMD_POINT, lo, lo, lo, 18'sh3FFFF, 18'sh3FFFF, 3));
		// a reference point away from the origin: scale keeps it fixed
		drain();
		write_refs(32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000);
		send_command(make_cmd(CMD_SCALE, 32'sh0002_0000, 32'sh0002_0000, 32'sh0000_8000,
			0, 0, 0));
		send_command(make_cmd(CMD_POINT, 0, 0, 0, 0, 0, 0));
		send_command(make_cmd(CMD_POINT, 32'sh0001_8000, -32'sh0002_4000, 32'sh0003_0000,
			0, 0, 0));
	endtask

	// mostly well-formed runs (optional reset, a few compositions, some points)
	// with moderate values, plus some commands with every field random
	task automatic test_random_sequences(input int n_items);
		int       sent;
		int       n_ops;
		int       n_pts;
		command_t it;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 99) < 15) begin
				send_command(noise_cmd());
				sent++;
			end else begin
				if ($urandom_range(0, 1) == 1) begin
					send_command(make_cmd(CMD_IDENT, $urandom, $urandom, $urandom,
						$urandom, $urandom, $urandom_range(0, 3)));
					sent++;
				end
				n_ops = $urandom_range(1, 4);
				for (int i = 0; i < n_ops; i++) begin
					it = noise_cmd();
					it.cmd = cmd_t'($urandom_range(CMD_TRANS, CMD_MIRROR));
					case (it.cmd)
						CMD_TRANS: begin
							it.a = spread(32'h0200_0000);
							it.b = spread(32'h0200_0000);
							it.c = spread(32'h0200_0000);
						end
						CMD_SCALE: begin
							it.a = spread(32'h0004_0000);
							it.b = spread(32'h0004_0000);
							it.c = spread(32'h0004_0000);
						end
						CMD_MIRROR:
							it.plane = $urandom_range(0, 2);
						default: begin
							it.cs = spread(32'h0001_0000);
							it.sn = spread(32'h0001_0000);
						end
					endcase
					send_command(it);
					sent++;
				end
				n_pts = $urandom_range(1, 5);
				for (int i = 0; i < n_pts; i++) begin
					it = noise_cmd();
					it.cmd = CMD_POINT;
					// now and then a point large enough to saturate
					if ($urandom_range(0, 9) != 0) begin
						it.a = spread(32'h0400_0000);
						it.b = spread(32'h0400_0000);
						it.c = spread(32'h0400_0000);
					end
					send_command(it);
					sent++;
				end
			end
		end
	endtask

	// output held off for a long stretch while commands keep coming, so the
	// block fills up and stalls its input
	task automatic test_output_backpressure();
		command_t it;
		hold_pending = 1'b1;
		for (int i = 0; i < 30; i++) begin
			it = noise_cmd();
			if (i % 4 != 3) begin
				it.cmd = CMD_POINT;
				it.a   = spread(32'h0100_0000);
				it.b   = spread(32'h0100_0000);
				it.c   = spread(32'h0100_0000);
			end else begin
				it.cmd = CMD_ROTY;
				it.cs  = spread(32'h0001_0000);
				it.sn  = spread(32'h0001_0000);
			end
			send_command(it);
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		unit_matrix(xform);
		ref_pt = '{0, 0, 0};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender rarely idle, receiver mostly stalled
		send_idle_pct = 9;
		recv_idle_pct = 88;
		test_directed_commands();
		drain();
		write_refs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
		test_random_sequences(400);

		// sender mostly idle, receiver rarely stalled
		drain();
		write_refs(spread(32'h0100_0000), spread(32'h0100_0000), spread(32'h0100_0000));
		send_idle_pct = 88;
		recv_idle_pct = 9;
		test_random_sequences(400);

		// full rate on both sides, apart from a long output hold-off
		drain();
		write_refs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_backpressure();
		drain();
		write_refs(spread(32'h0040_0000), spread(32'h0040_0000), spread(32'h0040_0000));
		test_random_sequences(400);

		drain();
		if (mismatches == 0 && pending_points.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ===== affine_transform_accumulator_3d_unit.f =====
+incdir+rtl
rtl/atac_pkg.sv
rtl/atac_mac.sv
rtl/affine_transform_accumulator_3d_unit.sv
sim/affine_transform_accumulator_3d_unit_test.sv
